/* sv/sap_pkg.sv */
// Shared types and constants of the sample average packetizer.
package sap_pkg;

	// Item kinds carried in s_tuser.
	localparam logic [1:0] OP_WORD = 2'd0;
	localparam logic [1:0] OP_TICK = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	// Report layout.
	localparam int          REPORT_BYTES = 64;
	localparam int          IDX_W        = $clog2(REPORT_BYTES);
	localparam logic [IDX_W-1:0] POS_ID       = IDX_W'(0);
	localparam logic [IDX_W-1:0] POS_MARK     = IDX_W'(1);
	localparam logic [IDX_W-1:0] POS_COUNT    = IDX_W'(2);
	localparam logic [IDX_W-1:0] POS_NUM_LO   = IDX_W'(3);
	localparam logic [IDX_W-1:0] POS_NUM_HI   = IDX_W'(4);
	localparam logic [IDX_W-1:0] POS_DELTA_0  = IDX_W'(5);
	localparam logic [IDX_W-1:0] POS_DELTA_1  = IDX_W'(6);
	localparam logic [IDX_W-1:0] POS_DELTA_2  = IDX_W'(7);
	localparam logic [IDX_W-1:0] POS_DELTA_3  = IDX_W'(8);
	localparam logic [IDX_W-1:0] HDR_BYTES    = IDX_W'(9);
	localparam logic [IDX_W-1:0] POS_LAST     = IDX_W'(REPORT_BYTES - 1);
	localparam logic [7:0]       REPORT_ID    = 8'h01;
	localparam logic [7:0]       REPORT_MARK  = 8'hFF;

	// Averaging: one dropped word, then eight summed words.
	localparam logic [3:0] AVG_LAST = 4'd8;

	localparam logic [4:0] SPP_RESET = 5'd25;

	// Tick increments repeat 31, 31, 31, 32.
	function automatic logic [5:0] tick_step(input logic [1:0] step);
		logic [5:0] val;
		val = (step == 2'd3) ? 6'd32 : 6'd31;
		return val;
	endfunction

	typedef struct packed {
		logic             word_en;
		logic             tick_en;
		logic             report_start;
		logic             issue;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic readable;
		logic advance;
		logic s1_busy;
	} status_t;

endpackage

/* sv/sample_average_packetizer.sv */
// Top level of the sample average packetizer.
//
//   channel  direction  handshake          payload
//   s_*      in         s_tvalid/s_tready  s_tdata conversion_word, s_tuser op
//   m_*      out        m_tvalid/m_tready  m_tdata report_byte, m_tlast last_byte
//   cfg_*    in         cfg_we             cfg_wdata packet length in samples
//
// A converter word, a tick or a read with nothing readable leaves the controller idle.
// A report read streams 64 bytes at one byte per cycle, when m_tready does not
// stall, through a two-register pipeline (store read, then output register);
// the next item is taken once the last byte has left the store read stage.
// Reset is asynchronous; the sample store needs no clearing pass.
// A stall on m_tready holds the byte pipeline and, during a report, the input.
module sample_average_packetizer #(
	parameter int MAX_SAMPLES = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] conversion_word
	input  logic [1:0]  s_tuser,   // [1:0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] report_byte
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata
);

	sap_pkg::cmd_t    cmd;
	sap_pkg::status_t status;

	sap_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.status   (status),
		.cmd      (cmd)
	);

	sap_datapath #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.conversion_word (s_tdata),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.m_tready        (m_tready),
		.m_tvalid        (m_tvalid),
		.m_tdata         (m_tdata),
		.m_tlast         (m_tlast),
		.status          (status)
	);

endmodule

/* sv/sap_controller.sv */
// Controller: input handshake, item decode and report byte sequencing.
module sap_controller (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [1:0]       s_tuser,
	input  sap_pkg::status_t status,
	output sap_pkg::cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_STREAM = 2'b10
	} state_t;

	state_t                    state_q;
	logic [sap_pkg::IDX_W-1:0] idx_q;
	logic                      accept;

	// A new item waits until the last report byte has left the first stage.
	assign s_tready = (state_q == ST_IDLE) && !status.s1_busy;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd.word_en      = accept && (s_tuser == sap_pkg::OP_WORD);
		cmd.tick_en      = accept && (s_tuser == sap_pkg::OP_TICK);
		cmd.report_start = accept && (s_tuser == sap_pkg::OP_READ) && status.readable;
		cmd.issue        = (state_q == ST_STREAM) && status.advance;
		cmd.idx          = idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.report_start) begin
						state_q <= ST_STREAM;
						idx_q   <= '0;
					end
				end
				ST_STREAM: begin
					if (cmd.issue) begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == sap_pkg::POS_LAST) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* sv/sap_datapath.sv */
// Datapath: averaging, tick total, ping-pong sample store and report byte pipeline.
module sap_datapath #(
	parameter int MAX_SAMPLES = 25
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sap_pkg::cmd_t    cmd,
	input  logic [15:0]      conversion_word,
	input  logic             cfg_we,
	input  logic [4:0]       cfg_wdata,
	input  logic             m_tready,
	output logic             m_tvalid,
	output logic [7:0]       m_tdata,
	output logic             m_tlast,
	output sap_pkg::status_t status
);

	localparam int DEPTH  = 2 * MAX_SAMPLES;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int FILL_W = $clog2(MAX_SAMPLES + 1);
	localparam logic [4:0]        MAX_LIM   = 5'(MAX_SAMPLES);
	localparam logic [ADDR_W-1:0] BUF1_BASE = ADDR_W'(MAX_SAMPLES);
	localparam logic [7:0]        MAX_CMP   = 8'(MAX_SAMPLES);

	logic [4:0]        spp_q;
	logic [3:0]        phase_q;
	logic [14:0]       sum_q;
	logic [FILL_W-1:0] fill_q [2];
	logic              wbuf_q;
	logic              rvalid_q;
	logic              rbuf_q;
	logic [15:0]       pkt_q;
	logic [31:0]       tick_q;
	logic [31:0]       last_q;
	logic [1:0]        step_q;
	logic [15:0]       stamp_num_q [2];
	logic [31:0]       stamp_delta_q [2];

	logic [11:0]       mem [DEPTH];

	logic [14:0]       sum_next;
	logic              avg_done;
	logic [11:0]       avg;
	logic              store;
	logic [FILL_W-1:0] cur_fill;
	logic              room;
	logic [FILL_W-1:0] fill_inc;
	logic [4:0]        limit;
	logic              close;
	logic [ADDR_W-1:0] waddr;
	logic [FILL_W-1:0] count;

	logic                      adv;
	logic [sap_pkg::IDX_W-1:0] rel;
	logic [4:0]                si;
	logic                      si_ok;
	logic [ADDR_W-1:0]         raddr;

	logic                      valid_s1;
	logic [sap_pkg::IDX_W-1:0] idx_s1;
	logic [11:0]               rd_s1;
	logic [sap_pkg::IDX_W-1:0] rel_s1;
	logic [4:0]                si_s1;
	logic [7:0]                byte_s1;

	logic       out_valid_q;
	logic [7:0] out_data_q;
	logic       out_last_q;

	// Averaging and sample store write.
	always_comb begin
		sum_next = (phase_q != 4'd0) ? (sum_q + 15'(conversion_word[15:4])) : sum_q;
		avg_done = (phase_q >= sap_pkg::AVG_LAST);
		avg      = sum_next[14:3];
		store    = cmd.word_en && avg_done;
		cur_fill = fill_q[wbuf_q];
		room     = (8'(cur_fill) < MAX_CMP);
		fill_inc = room ? (cur_fill + 1'b1) : cur_fill;
		limit    = ((spp_q == 5'd0) || (spp_q > MAX_LIM)) ? MAX_LIM : spp_q;
		close    = store && (8'(fill_inc) >= 8'(limit));
		waddr    = (wbuf_q ? BUF1_BASE : '0) + ADDR_W'(cur_fill);
		count    = fill_q[rbuf_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spp_q            <= sap_pkg::SPP_RESET;
			phase_q          <= '0;
			sum_q            <= '0;
			fill_q[0]        <= '0;
			fill_q[1]        <= '0;
			wbuf_q           <= 1'b0;
			rvalid_q         <= 1'b0;
			rbuf_q           <= 1'b0;
			pkt_q            <= '0;
			tick_q           <= '0;
			last_q           <= '0;
			step_q           <= '0;
			stamp_num_q[0]   <= '0;
			stamp_num_q[1]   <= '0;
			stamp_delta_q[0] <= '0;
			stamp_delta_q[1] <= '0;
		end else begin
			if (cfg_we) begin
				spp_q <= cfg_wdata;
			end
			if (cmd.word_en) begin
				if (avg_done) begin
					sum_q   <= '0;
					phase_q <= '0;
				end else begin
					sum_q   <= sum_next;
					phase_q <= phase_q + 1'b1;
				end
			end
			if (store) begin
				fill_q[wbuf_q] <= fill_inc;
			end
			if (close) begin
				pkt_q                 <= pkt_q + 1'b1;
				stamp_num_q[wbuf_q]   <= pkt_q + 1'b1;
				stamp_delta_q[wbuf_q] <= tick_q - last_q;
				last_q                <= tick_q;
				fill_q[~wbuf_q]       <= '0;
				wbuf_q                <= ~wbuf_q;
				rbuf_q                <= wbuf_q;
				rvalid_q              <= 1'b1;
			end else if (cmd.report_start) begin
				rvalid_q <= 1'b0;
			end
			if (cmd.tick_en) begin
				tick_q <= tick_q + 32'(sap_pkg::tick_step(step_q));
				step_q <= step_q + 1'b1;
			end
		end
	end

	// Report pipeline: stage 1 reads the store, the output register holds the byte formed from it.
	assign adv = !out_valid_q || m_tready;

	always_comb begin
		rel   = cmd.idx - sap_pkg::HDR_BYTES;
		si    = 5'(rel[sap_pkg::IDX_W-1:1]);
		si_ok = (cmd.idx >= sap_pkg::HDR_BYTES) && (8'(si) < MAX_CMP);
		raddr = (rbuf_q ? BUF1_BASE : '0) + (si_ok ? ADDR_W'(si) : '0);
	end

	always_ff @(posedge clk) begin
		if (store && room) begin
			mem[waddr] <= avg;
		end
		if (adv) begin
			rd_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else if (adv) begin
			valid_s1    <= cmd.issue;
			out_valid_q <= valid_s1;
			out_last_q  <= valid_s1 && (idx_s1 == sap_pkg::POS_LAST);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1     <= cmd.idx;
			out_data_q <= byte_s1;
		end
	end

	always_comb begin
		rel_s1  = idx_s1 - sap_pkg::HDR_BYTES;
		si_s1   = 5'(rel_s1[sap_pkg::IDX_W-1:1]);
		byte_s1 = '0;
		case (idx_s1)
			sap_pkg::POS_ID:      byte_s1 = sap_pkg::REPORT_ID;
			sap_pkg::POS_MARK:    byte_s1 = sap_pkg::REPORT_MARK;
			sap_pkg::POS_COUNT:   byte_s1 = 8'(count);
			sap_pkg::POS_NUM_LO:  byte_s1 = stamp_num_q[rbuf_q][7:0];
			sap_pkg::POS_NUM_HI:  byte_s1 = stamp_num_q[rbuf_q][15:8];
			sap_pkg::POS_DELTA_0: byte_s1 = stamp_delta_q[rbuf_q][7:0];
			sap_pkg::POS_DELTA_1: byte_s1 = stamp_delta_q[rbuf_q][15:8];
			sap_pkg::POS_DELTA_2: byte_s1 = stamp_delta_q[rbuf_q][23:16];
			sap_pkg::POS_DELTA_3: byte_s1 = stamp_delta_q[rbuf_q][31:24];
			default: begin
				// Each sample is two bytes, low byte first; past the count only padding.
				if ((idx_s1 >= sap_pkg::HDR_BYTES) && (8'(si_s1) < 8'(count))) begin
					byte_s1 = rel_s1[0] ? {4'b0000, rd_s1[11:8]} : rd_s1[7:0];
				end
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	always_comb begin
		status.readable = rvalid_q;
		status.advance  = adv;
		status.s1_busy  = valid_s1;
	end

endmodule

/* sv/sap_checker.sv */
// Port-level checks of the sample average packetizer, bound to the top level.
module sap_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast
);

	logic first_q;

	// Set while the next output item is the first byte of a report.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
		end else if (m_tvalid && m_tready) begin
			first_q <= m_tlast;
		end
	end

	// A stalled output item holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output item changed while stalled");

	// No input item is taken while a report is still short of its last byte.
	a_no_input_mid_report: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input taken in the middle of a report");

	// The final report byte is always padding.
	a_last_is_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata == 8'h00)
		else $error("last report byte is not padding");

	// Every report starts with the ID byte.
	a_report_id: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && first_q |-> m_tdata == 8'h01)
		else $error("report does not start with the ID byte");

endmodule

bind sample_average_packetizer sap_checker u_sap_checker (.*);
